// ===== rtl/tsat_pkg.sv =====
package tsat_pkg;

  localparam int unsigned MaxVars    = 32;
  localparam int unsigned MaxClauses = 64;

  localparam int unsigned VarW    = 6;
  localparam int unsigned IdxW    = $clog2(MaxClauses);
  localparam int unsigned CountW  = $clog2(MaxClauses + 1);
  localparam int unsigned NumVarW = 6;
  localparam int unsigned AssignW = 32;
  localparam int unsigned CfgW    = 7;

  localparam logic CfgNumVars    = 1'b0;
  localparam logic CfgNumClauses = 1'b1;

  localparam logic KindWrite = 1'b0;
  localparam logic KindTest  = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [IdxW-1:0] clause_index;
    logic [VarW-1:0] var_a;
    logic            neg_a;
    logic [VarW-1:0] var_b;
    logic            neg_b;
    logic [VarW-1:0] var_c;
    logic            neg_c;
  } in_t;

  typedef struct packed {
    logic [AssignW-1:0] assignment;
    logic               satisfied;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [VarW-1:0] var_a;
    logic            neg_a;
    logic [VarW-1:0] var_b;
    logic            neg_b;
    logic [VarW-1:0] var_c;
    logic            neg_c;
  } clause_t;

endpackage

// ===== rtl/three_sat_brute_force_checker.sv =====
// Brute-force 3-SAT checker. A kind-0 transaction writes one clause into a
// 64-entry clause RAM and restarts the enumeration; it leaves the block idle
// and returns nothing. A kind-1 transaction takes the next assignment from the
// enumeration counter and walks the first min(num_clauses, 64) entries of the
// clause RAM one clause per cycle, then waits for the output register to be
// free. The result sits in an output register, so a new transaction can start
// while it waits to be taken. The clause RAM has no reset; reading a clause
// that was never written gives undefined results. num_vars and num_clauses may
// only be written while idle.
module three_sat_brute_force_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  tsat_pkg::in_t          in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tsat_pkg::out_t         out_data_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [tsat_pkg::CfgW-1:0] cfg_data_i
);
  import tsat_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [NumVarW-1:0]   num_vars_q;
  logic [CountW-1:0]    num_clauses_q;
  logic [AssignW-1:0]   counter_q;
  logic [AssignW-1:0]   assign_q;
  logic [NumVarW-1:0]   n_q;
  logic [CountW-1:0]    nc_q;
  logic [CountW-1:0]    idx_q;
  logic                 rd_v_q;
  logic                 sat_q;
  logic                 last_q;
  logic                 out_valid_q;
  out_t                 out_q;

  clause_t              mem [MaxClauses];
  clause_t              rdata_q;
  clause_t              wr_clause;

  logic                 in_acc;
  logic                 out_free;
  logic                 issue;
  logic                 mem_we;
  logic [NumVarW-1:0]   n_eff;
  logic [CountW-1:0]    nc_eff;
  logic [AssignW-1:0]   mask;
  logic [AssignW-1:0]   cnt;
  logic [AssignW-1:0]   rev;
  logic [AssignW-1:0]   assign_new;
  logic                 clause_ok;

  function automatic logic lit_true(logic [AssignW-1:0] asg, logic [NumVarW-1:0] n,
                                    logic [VarW-1:0] v, logic neg);
    logic            val;
    logic [VarW-1:0] pos;
    pos = v - VarW'(1);
    val = 1'b0;
    if (v != '0 && v <= VarW'(n)) begin
      val = asg[pos[$clog2(AssignW)-1:0]];
    end
    return val ^ neg;
  endfunction

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    n_eff = num_vars_q;
    if (num_vars_q == '0) begin
      n_eff = NumVarW'(1);
    end else if (num_vars_q > NumVarW'(MaxVars)) begin
      n_eff = NumVarW'(MaxVars);
    end
    nc_eff = (num_clauses_q > CountW'(MaxClauses)) ? CountW'(MaxClauses) : num_clauses_q;
  end

  always_comb begin
    mask = AssignW'((33'd1 << n_eff) - 33'd1);
    cnt  = counter_q & mask;
    for (int j = 0; j < AssignW; j++) begin
      rev[AssignW-1-j] = cnt[j];
    end
    // variable v is counter digit n-v, inverted
    assign_new = (~rev) >> (NumVarW'(AssignW) - n_eff);
  end

  assign clause_ok = lit_true(assign_q, n_q, rdata_q.var_a, rdata_q.neg_a)
                  || lit_true(assign_q, n_q, rdata_q.var_b, rdata_q.neg_b)
                  || lit_true(assign_q, n_q, rdata_q.var_c, rdata_q.neg_c);

  assign issue  = (state_q == StScan) && (idx_q < nc_q);
  assign mem_we = in_acc && (in_data_i.kind == KindWrite);

  assign wr_clause = '{var_a: in_data_i.var_a, neg_a: in_data_i.neg_a,
                       var_b: in_data_i.var_b, neg_b: in_data_i.neg_b,
                       var_c: in_data_i.var_c, neg_c: in_data_i.neg_c};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_data_i.clause_index] <= wr_clause;
    end
    if (issue) begin
      rdata_q <= mem[idx_q[IdxW-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.kind == KindTest) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (!issue && !rd_v_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      num_vars_q    <= NumVarW'(3);
      num_clauses_q <= '0;
      counter_q     <= '0;
      idx_q         <= '0;
      rd_v_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgNumVars:    num_vars_q    <= cfg_data_i[NumVarW-1:0];
          CfgNumClauses: num_clauses_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_data_i.kind == KindWrite) begin
          counter_q <= '0;
        end else begin
          counter_q <= (cnt + AssignW'(1)) & mask;
          idx_q     <= '0;
        end
      end
      if (issue) begin
        idx_q <= idx_q + CountW'(1);
      end
      rd_v_q <= issue;
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.kind == KindTest) begin
      assign_q <= assign_new;
      n_q      <= n_eff;
      nc_q     <= nc_eff;
      last_q   <= (cnt == mask);
      sat_q    <= 1'b1;
    end else if (state_q == StScan && rd_v_q) begin
      sat_q <= sat_q & clause_ok;
    end
    if (state_q == StDone && out_free) begin
      out_q <= '{assignment: assign_q, satisfied: sat_q, last: last_q};
    end
  end

endmodule
